### src/text_console_writer_top_macros.svh
// Assertion macros for the text console writer RTL.
// Files that check their own logic include this header; it depends on nothing.
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tcw_pkg.sv
// Shared types and constants of the text console writer.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam logic [1:0]  CMD_PUT      = 2'd0;
    localparam logic [1:0]  CMD_CLEAR    = 2'd1;
    localparam logic [1:0]  CMD_READ     = 2'd2;
    localparam logic [7:0]  NEWLINE_CODE = 8'd10;
    localparam logic [15:0] BLANK_CELL   = 16'h0F20;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_COPY,
        ST_DRAIN,
        ST_BLANK,
        ST_WIPE,
        ST_FINISH
    } tcw_state_t;

    typedef struct packed {
        logic accept;
        logic exec_put;
        logic home;
        logic issue_read;
        logic sweep_start;
        logic clear_step;
        logic copy_step;
        logic blank_step;
        logic finish;
    } tcw_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       put_scroll;
        logic       copy_last;
        logic       sweep_last;
        logic       out_free;
    } tcw_status_t;

endpackage

`default_nettype wire

### src/tcw_datapath.sv
// Datapath of the text console writer: cell memory, cursor, sweep counter and result register.
// Driven by tcw_ctrl through tcw_cmd_t; depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire tcw_cmd_t    cmd,
    output tcw_status_t      status,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  char_code,
    input  wire logic [7:0]  color,
    input  wire logic [10:0] cell_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [10:0]      cursor_position,
    output logic [15:0]      cell_data,
    output logic             scrolled
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int EXT_W  = ADDR_W + 11;

    localparam logic [COL_W:0]      COL_END    = COLUMNS[COL_W:0];
    localparam logic [ROW_W:0]      ROW_END    = ROWS[ROW_W:0];
    localparam logic [ADDR_W-1:0]   COLUMNS_A  = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0]   COPY_LAST  = ADDR_W'(COLUMNS * (ROWS - 1) - 1);
    localparam logic [ADDR_W-1:0]   SWEEP_LAST = ADDR_W'(CELLS - 1);
    localparam logic [EXT_W-1:0]    CELLS_X    = EXT_W'(CELLS);

    logic [15:0] mem [CELLS];

    logic [1:0]        command_reg;
    logic [7:0]        char_reg;
    logic [7:0]        color_reg;
    logic [10:0]       index_reg;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic              scroll_flag_reg, scroll_flag_next;
    logic              pend_valid_reg;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic [15:0]       rd_data_reg;
    logic              out_valid_reg, out_valid_next;
    logic [10:0]       cursor_position_reg;
    logic [15:0]       cell_data_reg;
    logic              scrolled_reg;

    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic              is_newline;
    logic              wrap;
    logic              put_scroll;
    logic [ADDR_W-1:0] cur_pos;
    logic [EXT_W-1:0]  pos_ext;
    logic [EXT_W-1:0]  index_ext;
    logic              index_ok;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    assign is_newline = (char_reg == NEWLINE_CODE);
    assign col_inc    = {1'b0, col_reg} + 1'b1;
    assign row_inc    = {1'b0, row_reg} + 1'b1;
    assign wrap       = is_newline || (col_inc == COL_END);
    assign put_scroll = wrap && (row_inc == ROW_END);
    assign cur_pos    = ADDR_W'(row_reg) * COLUMNS_A + ADDR_W'(col_reg);
    assign pos_ext    = EXT_W'(cur_pos);
    assign index_ext  = EXT_W'(index_reg);
    assign index_ok   = (index_ext < CELLS_X);

    assign status.command    = command_reg;
    assign status.put_scroll = put_scroll;
    assign status.copy_last  = (sweep_reg == COPY_LAST);
    assign status.sweep_last = (sweep_reg == SWEEP_LAST);
    assign status.out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.home)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (cmd.exec_put)
        begin
            col_next = wrap ? '0 : col_inc[COL_W-1:0];
            if (wrap && !put_scroll)
            begin
                row_next = row_inc[ROW_W-1:0];
            end
        end
    end

    always_comb
    begin
        sweep_next = sweep_reg;
        if (cmd.sweep_start)
        begin
            sweep_next = '0;
        end
        else if (cmd.clear_step || cmd.copy_step || cmd.blank_step)
        begin
            sweep_next = sweep_reg + 1'b1;
        end
    end

    always_comb
    begin
        scroll_flag_next = scroll_flag_reg;
        if (cmd.accept)
        begin
            scroll_flag_next = 1'b0;
        end
        else if (cmd.exec_put)
        begin
            scroll_flag_next = put_scroll;
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = sweep_reg;
        mem_wdata = BLANK_CELL;
        if (cmd.clear_step || cmd.blank_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.exec_put && !is_newline)
        begin
            mem_we    = 1'b1;
            mem_waddr = cur_pos;
            mem_wdata = {color_reg, char_reg};
        end
        else if (pend_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr_reg;
            mem_wdata = rd_data_reg;
        end
    end

    always_comb
    begin
        mem_re    = cmd.issue_read || cmd.copy_step;
        mem_raddr = cmd.issue_read ? index_ext[ADDR_W-1:0] : sweep_reg + COLUMNS_A;
    end

    assign out_valid_next = cmd.finish ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            sweep_reg       <= '0;
            scroll_flag_reg <= 1'b0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            col_reg         <= col_next;
            row_reg         <= row_next;
            sweep_reg       <= sweep_next;
            scroll_flag_reg <= scroll_flag_next;
            pend_valid_reg  <= cmd.copy_step;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= sweep_reg;
        if (cmd.accept)
        begin
            command_reg <= command;
            char_reg    <= char_code;
            color_reg   <= color;
            index_reg   <= cell_index;
        end
        if (cmd.finish)
        begin
            cursor_position_reg <= pos_ext[10:0];
            cell_data_reg       <= (command_reg == CMD_READ && index_ok) ? rd_data_reg : 16'd0;
            scrolled_reg        <= scroll_flag_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign cursor_position = cursor_position_reg;
    assign cell_data       = cell_data_reg;
    assign scrolled        = scrolled_reg;

endmodule

`default_nettype wire

### src/tcw_ctrl.sv
// Controller of the text console writer: sequences each request and the memory sweeps.
// Drives tcw_datapath through tcw_cmd_t; depends on tcw_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_writer_top_macros.svh"

module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire tcw_status_t status,
    output tcw_cmd_t         cmd
);

    tcw_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (status.command)
                    CMD_PUT:   state_next = status.put_scroll ? ST_COPY : ST_FINISH;
                    CMD_CLEAR: state_next = ST_WIPE;
                    CMD_READ:  state_next = ST_READ_WAIT;
                    default:   state_next = ST_FINISH;
                endcase
            end
            ST_READ_WAIT:
            begin
                state_next = ST_FINISH;
            end
            ST_COPY:
            begin
                if (status.copy_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_BLANK;
            end
            ST_BLANK, ST_WIPE:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_INIT, ST_WIPE:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_EXEC:
            begin
                case (status.command)
                    CMD_PUT:
                    begin
                        cmd.exec_put    = 1'b1;
                        cmd.sweep_start = 1'b1;
                    end
                    CMD_CLEAR:
                    begin
                        cmd.home        = 1'b1;
                        cmd.sweep_start = 1'b1;
                    end
                    CMD_READ:
                    begin
                        cmd.issue_read = 1'b1;
                    end
                    default:
                    begin
                        cmd.finish = 1'b0;
                    end
                endcase
            end
            ST_COPY:
            begin
                cmd.copy_step = 1'b1;
            end
            ST_BLANK:
            begin
                cmd.blank_step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `TCW_ASSERT_NOW(a_finish_slot_free, cmd.finish, status.out_free, "result loaded while output held")
    `TCW_ASSERT_NOW(a_one_writer, 1'b1,
        $onehot0({cmd.clear_step, cmd.copy_step, cmd.blank_step, cmd.exec_put}),
        "more than one memory write source")
    `TCW_ASSERT_NEXT(a_scroll_starts_copy,
        state_reg == ST_EXEC && status.command == CMD_PUT && status.put_scroll,
        state_reg == ST_COPY, "scroll did not start the copy sweep")
    `TCW_ASSERT_NEXT(a_copy_drains, state_reg == ST_COPY && status.copy_last,
        state_reg == ST_DRAIN, "copy sweep did not drain")
    `TCW_ASSERT_NEXT(a_accept_executes, cmd.accept, state_reg == ST_EXEC,
        "accepted request not executed")

endmodule

`default_nettype wire

### src/text_console_writer_top.sv
// Text console writer: a text-mode character console holding ROWS by COLUMNS 16-bit cells
// (character in bits 7..0, attribute in bits 15..8) and a cursor. Each request gives exactly
// one result. After reset the block blanks the whole cell memory, one cell per cycle, before
// it takes its first request. A read passes through a wait state (ST_READ_WAIT) after it runs,
// since the cell memory has a registered read port. A put that scrolls adds a copy sweep, a
// drain state and a blanking sweep, and a clear adds a sweep that blanks the whole memory;
// all sweeps run through the one memory write port at one cell per cycle. A result waits in
// the output register while the next request is accepted; while that result is held by
// out_stall, the block does not load the following result.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_top
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  char_code,
    input  wire logic [7:0]  color,
    input  wire logic [10:0] cell_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [10:0]      cursor_position,
    output logic [15:0]      cell_data,
    output logic             scrolled
);

    tcw_cmd_t    cmd;
    tcw_status_t status;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .command         (command),
        .char_code       (char_code),
        .color           (color),
        .cell_index      (cell_index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cursor_position (cursor_position),
        .cell_data       (cell_data),
        .scrolled        (scrolled)
    );

endmodule

`default_nettype wire
